// File: rtl/core/segment_descriptor_cache_translate_top_defines.svh
// ----------------------------------------------------------------------------
// Segment descriptor cache translate: assertion macros
// Concurrent assertion helpers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DESCRIPTOR_CACHE_TRANSLATE_TOP_DEFINES_SVH
`define SEGMENT_DESCRIPTOR_CACHE_TRANSLATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a property at every clock edge outside reset
`define SDCT_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check a property at every clock edge, reset included
`define SDCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDCT_ASSERT_RST(label, clk, rstn, prop, msg)
`define SDCT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/core/sdct_pkg.sv
// ----------------------------------------------------------------------------
// sdct_pkg
// Types, codes and constants shared by the descriptor cache translator.
// ----------------------------------------------------------------------------
package sdct_pkg;

    // default number of segment registers with a cache entry
    localparam int NUM_SEGMENT_REGS_DEF = 4;

    // code segment register number and its flat reset descriptor
    localparam logic [1:0]  CS_SEG         = 2'd1;
    localparam logic [63:0] CS_RESET_DESC  = 64'h000F_8000_0000_FFFF;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_XLATE_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GDT_BASE = 1'd1;

    // input item modes
    localparam logic MODE_TRANSLATE = 1'b0;
    localparam logic MODE_FILL      = 1'b1;

    // result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_MISS        = 3'd1;
    localparam logic [2:0] STATUS_NOT_PRESENT = 3'd2;
    localparam logic [2:0] STATUS_PRIVILEGE   = 3'd3;
    localparam logic [2:0] STATUS_LIMIT       = 3'd4;
    localparam logic [2:0] STATUS_BASE_NZ     = 3'd5;
    localparam logic [2:0] STATUS_STRAY_FILL  = 3'd6;

    typedef struct packed {
        logic        mode;
        logic [31:0] offset;
        logic [1:0]  seg_reg;
        logic [12:0] sel_index;
        logic [1:0]  sel_rpl;
        logic [1:0]  code_rpl;
        logic [31:0] desc_low;
        logic [31:0] desc_high;
    } in_item_t;

    typedef struct packed {
        logic [31:0] linear_address;
        logic [2:0]  status;
        logic [31:0] fetch_address;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic commit;   // evaluate, update cache state, load result
    } ctrl_cmd_t;

endpackage

// File: rtl/core/sdct_ctrl.sv
// ----------------------------------------------------------------------------
// sdct_ctrl
// Sequencer: takes one item, runs it through the datapath, holds result valid.
// ----------------------------------------------------------------------------
module sdct_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sdct_pkg::ctrl_cmd_t cmd
);
    import sdct_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // result register can take a new value
    assign out_free    = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cmd.capture = s_valid && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/core/sdct_dpath.sv
// ----------------------------------------------------------------------------
// sdct_dpath
// Descriptor cache entries, pending miss, config registers and the checks.
// ----------------------------------------------------------------------------
module sdct_dpath #(
    parameter int NUM_SEGMENT_REGS = sdct_pkg::NUM_SEGMENT_REGS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sdct_pkg::ctrl_cmd_t             cmd,
    input  sdct_pkg::in_item_t              s_item,
    output sdct_pkg::out_item_t             m_item,
    input  logic                            cfg_we,
    input  logic [sdct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import sdct_pkg::*;

    localparam int SEG_IDX_W = (NUM_SEGMENT_REGS > 1) ? $clog2(NUM_SEGMENT_REGS) : 1;

    // config
    logic        xlate_on_reg;
    logic [31:0] gdt_base_reg;

    // captured item and result
    in_item_t    item_reg;
    out_item_t   result_reg, result_next;

    // cache entries
    logic        entry_valid_reg [NUM_SEGMENT_REGS];
    logic [12:0] entry_tag_reg   [NUM_SEGMENT_REGS];
    logic [63:0] entry_desc_reg  [NUM_SEGMENT_REGS];

    // pending miss
    logic                 pend_valid_reg, pend_valid_next;
    logic [31:0]          pend_offset_reg;
    logic [SEG_IDX_W-1:0] pend_seg_reg;
    logic [12:0]          pend_index_reg;
    logic [1:0]           pend_rpl_reg;
    logic [1:0]           pend_crpl_reg;

    logic                 seg_in_range;
    logic [SEG_IDX_W-1:0] item_seg_idx;
    logic                 hit;
    logic                 ent_we;
    logic                 pend_load;
    logic [63:0]          fill_desc;

    // present, privilege, limit and base checks on one descriptor
    function automatic out_item_t check_desc(input logic [63:0] d, input logic [31:0] ofs,
                                             input logic [12:0] idx, input logic [1:0] rpl,
                                             input logic [1:0] crpl);
        out_item_t   r;
        logic [1:0]  dpl;
        logic [19:0] limit;
        logic [31:0] base;
        r     = '0;
        dpl   = d[46:45];
        limit = {d[51:48], d[15:0]};
        base  = {d[63:56], d[39:32], d[31:16]};
        if (!d[47]) begin
            r.status = STATUS_NOT_PRESENT;
        end else if (crpl > dpl || rpl > dpl) begin
            r.status = STATUS_PRIVILEGE;
        end else if (!({4'd0, idx, 3'd0} < limit)) begin
            r.status = STATUS_LIMIT;
        end else begin
            r.linear_address = base + ofs;
            r.status         = (base != 32'd0) ? STATUS_BASE_NZ : STATUS_OK;
        end
        return r;
    endfunction

    assign seg_in_range = ({30'd0, item_reg.seg_reg} < 32'(NUM_SEGMENT_REGS));
    assign item_seg_idx = SEG_IDX_W'(item_reg.seg_reg);
    assign hit          = entry_valid_reg[item_seg_idx] &&
                          (entry_tag_reg[item_seg_idx] == item_reg.sel_index);
    assign fill_desc    = {item_reg.desc_high, item_reg.desc_low};
    assign m_item       = result_reg;

    // evaluate the captured item
    always_comb begin
        result_next     = '0;
        ent_we          = 1'b0;
        pend_load       = 1'b0;
        pend_valid_next = pend_valid_reg;
        if (item_reg.mode == MODE_FILL) begin
            if (!pend_valid_reg) begin
                result_next.status = STATUS_STRAY_FILL;
            end else begin
                pend_valid_next = 1'b0;
                ent_we          = 1'b1;
                result_next     = check_desc(fill_desc, pend_offset_reg, pend_index_reg,
                                             pend_rpl_reg, pend_crpl_reg);
            end
        end else begin
            pend_valid_next = 1'b0;
            if (!xlate_on_reg) begin
                result_next.linear_address = item_reg.offset;
            end else if (!seg_in_range) begin
                result_next.status = STATUS_NOT_PRESENT;
            end else if (hit) begin
                result_next = check_desc(entry_desc_reg[item_seg_idx], item_reg.offset,
                                         item_reg.sel_index, item_reg.sel_rpl,
                                         item_reg.code_rpl);
            end else begin
                pend_valid_next           = 1'b1;
                pend_load                 = 1'b1;
                result_next.status        = STATUS_MISS;
                result_next.fetch_address = gdt_base_reg + {16'd0, item_reg.sel_index, 3'd0};
            end
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xlate_on_reg <= 1'b0;
            gdt_base_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_XLATE_ON: xlate_on_reg <= cfg_data[0];
                CFG_GDT_BASE: gdt_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture, result load and pending request payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
        if (cmd.commit && pend_load) begin
            pend_offset_reg <= item_reg.offset;
            pend_seg_reg    <= item_seg_idx;
            pend_index_reg  <= item_reg.sel_index;
            pend_rpl_reg    <= item_reg.sel_rpl;
            pend_crpl_reg   <= item_reg.code_rpl;
        end
    end

    // pending valid and cache entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SEGMENT_REGS; i++) begin
                entry_valid_reg[i] <= (i == int'(CS_SEG));
                entry_tag_reg[i]   <= '0;
                entry_desc_reg[i]  <= (i == int'(CS_SEG)) ? CS_RESET_DESC : 64'd0;
            end
        end else if (cmd.commit) begin
            pend_valid_reg <= pend_valid_next;
            if (ent_we) begin
                entry_valid_reg[pend_seg_reg] <= 1'b1;
                entry_tag_reg[pend_seg_reg]   <= pend_index_reg;
                entry_desc_reg[pend_seg_reg]  <= fill_desc;
            end
        end
    end

endmodule

// File: rtl/core/segment_descriptor_cache_translate_top.sv
// ----------------------------------------------------------------------------
// segment_descriptor_cache_translate_top
// Segment offset to linear address translation with a per-register
// descriptor cache, miss reporting and descriptor fill.
// ----------------------------------------------------------------------------
//  channel  ports                       moves
//  s_       s_valid/s_ready/s_item      translate request or descriptor fill
//  m_       m_valid/m_ready/m_item      linear address, status, fetch address
//  cfg_     cfg_we/cfg_index/cfg_data   xlate_on, gdt_base writes
//
//  One item at a time: a capture state, then an evaluate state in which
//  the entry read, the checks and the base add run and the result loads.
//  A new item is taken while a result waits; evaluation holds if it still waits.
//  Synchronous active-low reset; no clearing pass, the CS entry resets flat.
// ----------------------------------------------------------------------------
`include "segment_descriptor_cache_translate_top_defines.svh"

module segment_descriptor_cache_translate_top #(
    parameter int NUM_SEGMENT_REGS = sdct_pkg::NUM_SEGMENT_REGS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sdct_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sdct_pkg::out_item_t            m_item,
    input  logic                           cfg_we,
    input  logic [sdct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import sdct_pkg::*;

    ctrl_cmd_t cmd;

    sdct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sdct_dpath #(
        .NUM_SEGMENT_REGS (NUM_SEGMENT_REGS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one item in flight at a time
    `SDCT_ASSERT_RST(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "busy accept")
    // capture and commit never coincide
    `SDCT_ASSERT_RST(a_cmd_excl, aclk, aresetn, !(cmd.capture && cmd.commit), "cmd overlap")
    // a commit always presents a result
    `SDCT_ASSERT_RST(a_commit_shows, aclk, aresetn, cmd.commit |=> m_valid, "result not shown")
    // reset leaves the block ready with no result
    `SDCT_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> s_ready && !m_valid, "busy after reset")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment descriptor cache translator. Items go
// in on the s_ channel while an in-bench predictor of the cache, the pending
// miss and the register state computes each expected result. The m_ results
// are compared field by field in order. A directed part covers pass-through,
// the flat code segment, miss and fill, failed checks, abandoned misses and
// stray fills. Random traffic, mostly miss/fill pairs, then runs under three
// idle profiles and several register settings.
// ----------------------------------------------------------------------------
module tb;
    import sdct_pkg::*;

    // segment register numbers, CS comes from the package
    localparam logic [1:0] SEG_ES = 2'd0;
    localparam logic [1:0] SEG_SS = 2'd2;
    localparam logic [1:0] SEG_DS = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // idle rates in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;

    // predicted block state
    logic        prot_on;
    logic [31:0] table_base;
    logic        seg_valid [NUM_SEGMENT_REGS_DEF];
    logic [12:0] seg_tag   [NUM_SEGMENT_REGS_DEF];
    logic [63:0] seg_desc  [NUM_SEGMENT_REGS_DEF];
    logic        miss_open;
    in_item_t    miss_req;

    out_item_t   expected_results [$];

    segment_descriptor_cache_translate_top #(
        .NUM_SEGMENT_REGS(NUM_SEGMENT_REGS_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present, privilege, limit and base checks on a cached descriptor
    function automatic out_item_t check_cached(input logic [1:0] seg,
                                               input logic [31:0] offset,
                                               input logic [12:0] index,
                                               input logic [1:0] rpl,
                                               input logic [1:0] crpl);
        logic [63:0] d;
        logic [1:0]  dpl;
        logic [19:0] limit;
        logic [31:0] base;
        logic [31:0] index_bytes;
        out_item_t   r;
        d           = seg_desc[seg];
        dpl         = d[46:45];
        limit       = {d[51:48], d[15:0]};
        base        = {d[63:56], d[39:32], d[31:16]};
        index_bytes = {16'd0, index, 3'd0};
        r           = '0;
        if (!d[47]) begin
            r.status = STATUS_NOT_PRESENT;
        end else if (crpl > dpl || rpl > dpl) begin
            r.status = STATUS_PRIVILEGE;
        end else if (!(index_bytes < {12'd0, limit})) begin
            r.status = STATUS_LIMIT;
        end else begin
            r.linear_address = base + offset;
            r.status         = (base != 32'd0) ? STATUS_BASE_NZ : STATUS_OK;
        end
        return r;
    endfunction

    // expected result of one accepted item; updates the predicted state
    function automatic out_item_t predict_translation(input in_item_t it);
        out_item_t r;
        r = '0;
        if (it.mode == MODE_FILL) begin
            if (!miss_open) begin
                r.status = STATUS_STRAY_FILL;
            end else begin
                miss_open                  = 1'b0;
                seg_desc[miss_req.seg_reg]  = {it.desc_high, it.desc_low};
                seg_tag[miss_req.seg_reg]   = miss_req.sel_index;
                seg_valid[miss_req.seg_reg] = 1'b1;
                r = check_cached(miss_req.seg_reg, miss_req.offset, miss_req.sel_index,
                                 miss_req.sel_rpl, miss_req.code_rpl);
            end
        end else begin
            // any request drops a pending miss
            miss_open = 1'b0;
            if (!prot_on) begin
                r.linear_address = it.offset;
                r.status         = STATUS_OK;
            end else if (seg_valid[it.seg_reg] && seg_tag[it.seg_reg] == it.sel_index) begin
                r = check_cached(it.seg_reg, it.offset, it.sel_index, it.sel_rpl, it.code_rpl);
            end else begin
                miss_open       = 1'b1;
                miss_req        = it;
                r.status        = STATUS_MISS;
                r.fetch_address = table_base + {16'd0, it.sel_index, 3'd0};
            end
        end
        return r;
    endfunction

    function automatic in_item_t make_request(input logic [1:0] seg, input logic [12:0] index,
                                              input logic [1:0] rpl, input logic [1:0] crpl,
                                              input logic [31:0] offset);
        in_item_t it;
        it           = '0;
        it.mode      = MODE_TRANSLATE;
        it.offset    = offset;
        it.seg_reg   = seg;
        it.sel_index = index;
        it.sel_rpl   = rpl;
        it.code_rpl  = crpl;
        // descriptor words are ignored on a request
        it.desc_low  = $urandom;
        it.desc_high = $urandom;
        return it;
    endfunction

    // fill item; all fields but the mode and the descriptor words are noise
    function automatic in_item_t make_fill(input logic [31:0] lo, input logic [31:0] hi);
        in_item_t it;
        it           = '0;
        it.mode      = MODE_FILL;
        it.offset    = $urandom;
        it.seg_reg   = 2'($urandom_range(3));
        it.sel_index = 13'($urandom);
        it.sel_rpl   = 2'($urandom_range(3));
        it.code_rpl  = 2'($urandom_range(3));
        it.desc_low  = lo;
        it.desc_high = hi;
        return it;
    endfunction

    // send one item after a random gap, predict it once accepted
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item  = it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_translation(it));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain_results();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_XLATE_ON) begin
            prot_on = data[0];
        end else begin
            table_base = data;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, m_item);
                mismatches++;
            end else begin
                out_item_t want;
                want = expected_results.pop_front();
                if (m_item.linear_address !== want.linear_address) begin
                    $display("%0t: linear_address expected %h actual %h", $time,
                             want.linear_address, m_item.linear_address);
                    mismatches++;
                end
                if (m_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_item.status);
                    mismatches++;
                end
                if (m_item.fetch_address !== want.fetch_address) begin
                    $display("%0t: fetch_address expected %h actual %h", $time,
                             want.fetch_address, m_item.fetch_address);
                    mismatches++;
                end
            end
        end
    end

    // protection off: offsets pass through, fill with nothing pending
    task automatic test_passthrough();
        send_item(make_request(SEG_ES, 13'd0, 2'd0, 2'd0, 32'h0000_0000));
        send_item(make_request(SEG_DS, 13'h1FFF, 2'd3, 2'd3, 32'hFFFF_FFFF));
        send_item(make_fill(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // code segment entry is valid and flat out of reset
    task automatic test_flat_code_segment();
        write_register(CFG_XLATE_ON, 32'd1);
        write_register(CFG_GDT_BASE, 32'd0);
        send_item(make_request(CS_SEG, 13'd0, 2'd0, 2'd0, 32'hFFFF_FFFF));
        send_item(make_request(CS_SEG, 13'd0, 2'd3, 2'd0, 32'h1234_5678));
        send_item(make_request(CS_SEG, 13'd0, 2'd0, 2'd1, 32'h1234_5678));
    endtask

    // miss with fetch address wrap, fill with all-ones descriptor, then hit
    task automatic test_miss_and_fill();
        write_register(CFG_GDT_BASE, 32'hFFFF_FFF8);
        send_item(make_request(SEG_ES, 13'h1FFF, 2'd3, 2'd3, 32'hFFFF_FFFF));
        send_item(make_fill(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_request(SEG_ES, 13'h1FFF, 2'd3, 2'd3, 32'h0000_0001));
    endtask

    // failing descriptors stay cached; limit boundary
    task automatic test_failed_checks();
        send_item(make_request(SEG_SS, 13'd5, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'h0000_0000, 32'h0000_0000));
        send_item(make_request(SEG_SS, 13'd5, 2'd0, 2'd0, $urandom));
        send_item(make_request(SEG_DS, 13'd4, 2'd2, 2'd0, $urandom));
        send_item(make_fill(32'h0000_FFFF, 32'h000F_8000));
        send_item(make_request(SEG_DS, 13'd4, 2'd0, 2'd0, $urandom));
        // limit equal to index*8 fails
        send_item(make_request(SEG_DS, 13'd2, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'h0000_0010, 32'h0000_E000));
        send_item(make_request(SEG_DS, 13'd2, 2'd1, 2'd1, $urandom));
        // limit one above index*8 passes
        send_item(make_request(SEG_ES, 13'd1, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'h0000_0009, 32'h0000_E000));
    endtask

    // a request abandons a pending miss; a later fill is stray
    task automatic test_abandoned_miss();
        send_item(make_request(SEG_ES, 13'd7, 2'd0, 2'd0, $urandom));
        send_item(make_request(CS_SEG, 13'd0, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'h0000_FFFF, 32'h000F_E000));
        send_item(make_request(SEG_SS, 13'd9, 2'd0, 2'd0, $urandom));
        send_item(make_request(SEG_DS, 13'd10, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'h0000_FFFF, 32'h000F_E000));
        send_item(make_request(SEG_SS, 13'd9, 2'd0, 2'd0, $urandom));
        send_item(make_fill(32'hABCD_FFFF, 32'h120F_E034));
    endtask

    // random descriptor, biased toward passing the checks
    function automatic logic [63:0] random_descriptor();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        if ($urandom_range(99) < 85) hi[15] = 1'b1;
        if ($urandom_range(99) < 60) hi[14:13] = 2'd3;
        if ($urandom_range(99) < 70) hi[19:16] = 4'hF;
        if ($urandom_range(99) < 40) begin
            hi[31:24] = 8'd0;
            hi[7:0]   = 8'd0;
            lo[31:16] = 16'd0;
        end
        return {hi, lo};
    endfunction

    // random traffic: mostly misses answered by fills, plus noise
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          pick;
        logic [63:0] d;
        logic [12:0] index;
        for (sent = 0; sent < n_items; sent++) begin
            // hold off once until all results are back
            if (sent == n_items / 2) drain_results();
            pick = $urandom_range(99);
            if ((miss_open && pick < 85) || (!miss_open && pick < 6)) begin
                d = random_descriptor();
                send_item(make_fill(d[31:0], d[63:32]));
            end else begin
                index = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(3));
                send_item(make_request(2'($urandom_range(3)), index,
                                       $urandom_range(1) ? 2'd0 : 2'($urandom_range(3)),
                                       $urandom_range(1) ? 2'd0 : 2'($urandom_range(3)),
                                       $urandom));
            end
        end
    endtask

    initial begin
        prot_on    = 1'b0;
        table_base = 32'd0;
        miss_open  = 1'b0;
        miss_req   = '0;
        for (int i = 0; i < NUM_SEGMENT_REGS_DEF; i++) begin
            seg_valid[i] = 1'b0;
            seg_tag[i]   = 13'd0;
            seg_desc[i]  = 64'd0;
        end
        seg_valid[CS_SEG] = 1'b1;
        seg_desc[CS_SEG]  = CS_RESET_DESC;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 74;
        test_passthrough();
        test_flat_code_segment();
        test_miss_and_fill();
        test_failed_checks();
        test_abandoned_miss();
        // stray fill with protection on
        send_item(make_fill($urandom, $urandom));

        // light sender gaps, heavy receiver stalls
        send_idle_pct = 13;
        recv_idle_pct = 74;
        write_register(CFG_GDT_BASE, $urandom);
        test_random_traffic(270);

        // heavy sender gaps, light receiver stalls
        send_idle_pct = 74;
        recv_idle_pct = 13;
        write_register(CFG_GDT_BASE, 32'd0);
        test_random_traffic(200);
        write_register(CFG_XLATE_ON, 32'd0);
        test_random_traffic(60);
        write_register(CFG_XLATE_ON, 32'd1);

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_GDT_BASE, 32'hFFFF_FFFF);
        test_random_traffic(270);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
